[design/nws_pkg.sv]
// shared types and constants for the neuron weighted sum and sigmoid block
package nws_pkg;

    localparam int VALUE_W = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 48;
    localparam int SUM_W   = 32;
    localparam int ACT_W   = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    // offset sum over the table range [-8,8), unsigned q4.16
    localparam int X_W = 20;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic                     missing;
        logic                     last;
    } item_t;

endpackage

[design/neuron_weighted_sum_sigmoid.sv]
// top level of the neuron: weighted sum with saturation and sigmoid activation
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata: input_value, input_weight; tuser: value_missing;
//                                         tlast: last_input
//  m_axis    out  tvalid/tready           tdata: weighted_sum, activation; tuser: activation_failed
//
//  one input transfer per cycle while the queue is not full; the single accumulator in the back end sets that rate
//  after its last input leaves the queue, a result passes the registers s1, s2, s3 and s4
//  asynchronous active-low reset clears the accumulator, queue and pipeline; the rom needs no fill
//  an output stall holds the back end; the input side keeps taking transfers until the
//  2-entry queue fills
module neuron_weighted_sum_sigmoid #(
    parameter int SIGMOID_ENTRIES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [nws_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // input_value, input_weight
    input  logic                           s_axis_tuser,  // value_missing
    input  logic                           s_axis_tlast,  // last_input
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [nws_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // weighted_sum, activation
    output logic                           m_axis_tuser   // activation_failed
);
    import nws_pkg::*;

    logic  push_valid;
    item_t push_item;
    logic  queue_full;
    logic  pop_valid;
    item_t pop_item;
    logic  pop;

    nws_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_item     (push_item),
        .queue_full    (queue_full)
    );

    nws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop)
    );

    nws_back #(
        .ENTRIES (SIGMOID_ENTRIES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_item      (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[design/nws_front.sv]
// input side: unpacks a transfer, forms the exact q16.16 product and tags it
module nws_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [nws_pkg::IN_DATA_W-1:0] s_axis_tdata,  // input_value, input_weight
    input  logic                          s_axis_tuser,  // value_missing
    input  logic                          s_axis_tlast,  // last_input
    output logic                          push_valid,
    output nws_pkg::item_t                push_item,
    input  logic                          queue_full
);
    import nws_pkg::*;

    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] weight;
    logic signed [PROD_W-1:0]  value_ext;
    logic signed [PROD_W-1:0]  weight_ext;

    assign value  = s_axis_tdata[VALUE_W-1:0];
    assign weight = s_axis_tdata[2*VALUE_W-1:VALUE_W];

    assign value_ext  = {{(PROD_W-VALUE_W){value[VALUE_W-1]}}, value};
    assign weight_ext = {{(PROD_W-VALUE_W){weight[VALUE_W-1]}}, weight};

    assign s_axis_tready = !queue_full;
    assign push_valid    = s_axis_tvalid;

    always_comb
    begin
        push_item.product = value_ext * weight_ext;
        push_item.missing = s_axis_tuser;
        push_item.last    = s_axis_tlast;
    end

endmodule

[design/nws_queue.sv]
// short queue of tagged products between the input side and the accumulator
module nws_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  nws_pkg::item_t push_item,
    output logic           full,
    output logic           pop_valid,
    output nws_pkg::item_t pop_item,
    input  logic           pop
);
    import nws_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    assign do_push = push_valid && !full;
    assign do_pop  = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[design/nws_rom.sv]
// sigmoid lookup rom, contents built at elaboration, registered read
module nws_rom #(
    parameter int ENTRIES = 1024
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [$clog2(ENTRIES)-1:0]   addr,
    output logic [nws_pkg::ACT_W-1:0]    data
);
    import nws_pkg::*;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    // shift-subtract divide, elaboration only
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        int              k;
        rem = '0;
        quo = '0;
        for (k = 63; k >= 0; k--)
        begin
            rem = {rem[62:0], num[k]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // taylor series of e^-(r/n) in q30
    function automatic longint exp_neg_frac(input longint unsigned r,
                                            input longint unsigned n);
        longint          sum;
        longint unsigned term;
        bit              done;
        int              k;
        sum  = longint'(Q30_ONE);
        term = Q30_ONE;
        done = 1'b0;
        for (k = 1; k <= 40; k++)
        begin
            if (!done)
            begin
                term = udiv(term * r, n * longint'(k));
                if (term == 0)
                begin
                    done = 1'b1;
                end
                else if (k[0])
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
        end
        return sum;
    endfunction

    function automatic logic [ACT_W-1:0] table_entry(input longint i,
                                                     input longint n);
        longint          num;
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned r;
        longint unsigned e1;
        longint unsigned t;
        longint unsigned den;
        longint unsigned p;
        longint unsigned k;
        num = 16 * i - 8 * n;
        neg = (num < 0);
        mag = neg ? longint'(-num) : longint'(num);
        q   = udiv(mag, longint'(n));
        r   = mag - q * longint'(n);
        e1  = exp_neg_frac(longint'(n), longint'(n));
        t   = exp_neg_frac(r, longint'(n));
        for (k = 0; k < q; k++)
        begin
            t = (t * e1 + (64'd1 << 29)) >> 30;
        end
        den = Q30_ONE + t;
        p   = udiv((64'd1 << 46) + (den >> 1), den);
        if (neg)
        begin
            p = 64'd65536 - p;
        end
        if (p > 64'd65535)
        begin
            p = 64'd65535;
        end
        return p[ACT_W-1:0];
    endfunction

    logic [ACT_W-1:0] rom_arr [ENTRIES];
    logic [ACT_W-1:0] data_reg;

    for (genvar gi = 0; gi < ENTRIES; gi++)
    begin : g_entry
        localparam logic [ACT_W-1:0] VAL = table_entry(longint'(gi), longint'(ENTRIES));
        assign rom_arr[gi] = VAL;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom_arr[addr];
        end
    end

    assign data = data_reg;

endmodule

[design/nws_back.sv]
// accumulator and result pipeline: saturate, table index, sigmoid lookup, output
module nws_back #(
    parameter int ENTRIES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    input  nws_pkg::item_t                 pop_item,
    output logic                           pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [nws_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // weighted_sum, activation
    output logic                           m_axis_tuser   // activation_failed
);
    import nws_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int NUM_W = $clog2(ENTRIES + 1);
    localparam int SCL_W = X_W + NUM_W;
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [SCL_W-1:0] ENTRIES_V = SCL_W'(ENTRIES);

    logic adv;

    // accumulate
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic             miss_reg;
    logic [ACC_W:0]   sum_wide;
    logic [ACC_W-1:0] sum_sat;
    logic             sum_ovf;

    logic             s1_valid_reg;
    logic             s1_failed_reg;
    logic [ACC_W-1:0] s1_sum_reg;

    logic             s2_valid_reg;
    logic             s2_failed_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic             s2_lo_reg;
    logic             s2_hi_reg;
    logic [X_W-1:0]   s2_x_reg;

    logic             s3_valid_reg;
    logic             s3_failed_reg;
    logic [SUM_W-1:0] s3_sum_reg;
    logic [IDX_W-1:0] s3_idx_reg;

    logic             s4_valid_reg;
    logic             s4_failed_reg;
    logic [SUM_W-1:0] s4_sum_reg;
    logic [ACT_W-1:0] rom_data;

    logic             fits32;
    logic [SUM_W-1:0] sum32;
    logic             below;
    logic             above;
    logic [SCL_W-1:0] scaled;
    logic [IDX_W-1:0] idx_next;

    assign adv = !s4_valid_reg || m_axis_tready;
    assign pop = pop_valid && adv;

    assign sum_wide = {acc_reg[ACC_W-1], acc_reg}
                    + {{(ACC_W+1-PROD_W){pop_item.product[PROD_W-1]}}, pop_item.product};
    assign sum_ovf  = sum_wide[ACC_W] ^ sum_wide[ACC_W-1];
    assign sum_sat  = sum_ovf ? (sum_wide[ACC_W] ? ACC_MIN : ACC_MAX) : sum_wide[ACC_W-1:0];
    assign acc_next = pop_item.last ? '0 : sum_sat;

    assign fits32 = (&s1_sum_reg[ACC_W-1:SUM_W-1]) || !(|s1_sum_reg[ACC_W-1:SUM_W-1]);
    assign sum32  = fits32 ? s1_sum_reg[SUM_W-1:0]
                           : (s1_sum_reg[ACC_W-1] ? SUM_MIN : SUM_MAX);
    assign below  = s1_sum_reg[ACC_W-1] && !(&s1_sum_reg[ACC_W-2:X_W-1]);
    assign above  = !s1_sum_reg[ACC_W-1] && (|s1_sum_reg[ACC_W-2:X_W-1]);

    assign scaled = SCL_W'(s2_x_reg) * ENTRIES_V;

    always_comb
    begin
        if (s2_lo_reg)
        begin
            idx_next = '0;
        end
        else if (s2_hi_reg)
        begin
            idx_next = MAX_IDX;
        end
        else
        begin
            idx_next = scaled[X_W +: IDX_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            miss_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (pop)
            begin
                acc_reg  <= acc_next;
                miss_reg <= !pop_item.last && (miss_reg || pop_item.missing);
            end
            s1_valid_reg <= pop && pop_item.last;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sum_reg    <= sum_sat;
            s1_failed_reg <= miss_reg || pop_item.missing;
            s2_failed_reg <= s1_failed_reg;
            s2_sum_reg    <= sum32;
            s2_lo_reg     <= below;
            s2_hi_reg     <= above;
            s2_x_reg      <= {~s1_sum_reg[X_W-1], s1_sum_reg[X_W-2:0]};
            s3_failed_reg <= s2_failed_reg;
            s3_sum_reg    <= s2_sum_reg;
            s3_idx_reg    <= idx_next;
            s4_failed_reg <= s3_failed_reg;
            s4_sum_reg    <= s3_sum_reg;
        end
    end

    nws_rom #(
        .ENTRIES (ENTRIES)
    ) u_rom (
        .clk  (clk),
        .en   (adv),
        .addr (s3_idx_reg),
        .data (rom_data)
    );

    assign m_axis_tvalid = s4_valid_reg;
    assign m_axis_tuser  = s4_failed_reg;
    assign m_axis_tdata  = s4_failed_reg ? '0 : {rom_data, s4_sum_reg};

endmodule

[design/nws_checker.sv]
// port-level checks for the neuron block and their bind
module nws_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [nws_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                           s_axis_tuser,
    input logic                           s_axis_tlast,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [nws_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);
    import nws_pkg::*;

    // no result while reset is held
    a_no_out_in_reset: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result shown during reset");

    // failed activation carries all-zero data
    a_failed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("failed activation with nonzero data");

    // activation lies on the side of one half given by the sign of the sum
    a_half_side: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser
        |-> (m_axis_tdata[SUM_W-1] ? (m_axis_tdata[OUT_DATA_W-1:SUM_W] <= 16'h8000)
                                   : (m_axis_tdata[OUT_DATA_W-1:SUM_W] >= 16'h8000)))
        else $error("activation on the wrong side of one half");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // stalled input transfer holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready
        |=> s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser)
            && $stable(s_axis_tlast))
        else $error("input changed while stalled");

endmodule

bind neuron_weighted_sum_sigmoid nws_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
